FILE: sv/rif_pkg.sv
// Package for the radial island falloff factor: widths, codes, payload types and coefficients.
package rif_pkg;

  localparam int COORD_WIDTH      = 24;
  localparam int FACTOR_FRAC_BITS = 16;
  localparam int RADIUS_WIDTH     = 23;
  localparam int WEIGHT_WIDTH     = 17;
  localparam int CFG_WIDTH        = 23;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int T_FRAC           = 24;
  localparam int SUMSQ_WIDTH      = 2 * COORD_WIDTH;
  localparam int READ_WIDTH       = (COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH;
  localparam int DIV_REM_WIDTH    = RADIUS_WIDTH + 1;
  localparam int Y_WIDTH          = 29;
  localparam int P_WIDTH          = 33;
  localparam int PROD_WIDTH       = 62;
  localparam int HORNER_STEPS     = 6;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INNER_RADIUS  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTER_RADIUS  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SQUARE_WEIGHT = 2'd2;

  localparam logic [1:0] REGION_ORIGIN  = 2'd0;
  localparam logic [1:0] REGION_INSIDE  = 2'd1;
  localparam logic [1:0] REGION_BAND    = 2'd2;
  localparam logic [1:0] REGION_OUTSIDE = 2'd3;

  localparam logic [RADIUS_WIDTH-1:0] INNER_RESET  = 23'd139668;
  localparam logic [RADIUS_WIDTH-1:0] OUTER_RESET  = 23'd174586;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 17'd26214;
  localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_ONE   = 17'd65536;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
  } item_t;

  typedef struct packed {
    logic [FACTOR_FRAC_BITS:0] factor;
    logic [1:0]                region;
  } result_t;

  // Even cosine series coefficients pi^(2n)/(2n)! in Q30.
  function automatic logic [P_WIDTH-1:0] cos_coeff(input int n);
    logic [P_WIDTH-1:0] c;
    case (n)
      1:       c = 33'd5298703516;
      2:       c = 33'd4358008962;
      3:       c = 33'd1433727481;
      4:       c = 33'd252684340;
      5:       c = 33'd27709939;
      6:       c = 33'd2071865;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/radial_island_falloff_factor.sv
// Radial island falloff factor: a fully pipelined distance, divide and cosine datapath.
// The square root takes one stage per root bit and the divider one stage per quotient bit.
// Throughput: one request per cycle; a stall on the result side holds the whole pipeline.
// Reset clears all valid bits and loads the default radii and weight.
module radial_island_falloff_factor (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  rif_pkg::item_t                       item,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output rif_pkg::result_t                     result,
  input  logic                                 cfg_write,
  input  logic [rif_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [rif_pkg::CFG_WIDTH-1:0]        cfg_data
);
  import rif_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F  = FACTOR_FRAC_BITS;
  localparam int DS = T_FRAC + 1;

  logic [RADIUS_WIDTH-1:0] inner_radius;
  logic [RADIUS_WIDTH-1:0] outer_radius;
  logic [WEIGHT_WIDTH-1:0] square_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius  <= INNER_RESET;
      outer_radius  <= OUTER_RESET;
      square_weight <= WEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INNER_RADIUS:  inner_radius  <= cfg_data[RADIUS_WIDTH-1:0];
        REG_OUTER_RADIUS:  outer_radius  <= cfg_data[RADIUS_WIDTH-1:0];
        REG_SQUARE_WEIGHT: square_weight <= cfg_data[WEIGHT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic                    adv;
  logic [RADIUS_WIDTH-1:0] span;
  logic                    empty_band;
  logic [WEIGHT_WIDTH-1:0] w_eff;
  logic [WEIGHT_WIDTH-1:0] w_inv;

  assign adv        = !(result_valid && result_stall);
  assign item_stall = rst || !adv;
  assign span       = outer_radius - inner_radius;
  assign empty_band = (outer_radius <= inner_radius);
  assign w_eff      = (square_weight > WEIGHT_ONE) ? WEIGHT_ONE : square_weight;
  assign w_inv      = WEIGHT_ONE - w_eff;

  // Magnitudes.
  logic [CW-1:0] mag_x;
  logic [CW-1:0] mag_z;
  logic          a_v;
  logic [CW-1:0] a_ax;
  logic [CW-1:0] a_az;
  logic          a_org;

  assign mag_x = item.x_coord[CW-1] ? (~item.x_coord + 1'b1) : item.x_coord;
  assign mag_z = item.z_coord[CW-1] ? (~item.z_coord + 1'b1) : item.z_coord;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ax  <= mag_x;
      a_az  <= mag_z;
      a_org <= (mag_x == '0) && (mag_z == '0);
    end
  end

  // Squares.
  logic                   b_v;
  logic [SUMSQ_WIDTH-1:0] b_sqx;
  logic [SUMSQ_WIDTH-1:0] b_sqz;
  logic [CW-1:0]          b_rect;
  logic                   b_org;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sqx  <= a_ax * a_ax;
      b_sqz  <= a_az * a_az;
      b_rect <= (a_ax > a_az) ? a_ax : a_az;
      b_org  <= a_org;
    end
  end

  // Square root, one root bit per stage.
  logic [SUMSQ_WIDTH-1:0] sq_rem  [0:CW];
  logic [CW-1:0]          sq_root [0:CW];
  logic [CW-1:0]          sq_rect [0:CW];
  logic                   sq_org  [0:CW];
  logic                   sq_v    [0:CW];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]  <= b_sqx + b_sqz;
      sq_root[0] <= '0;
      sq_rect[0] <= b_rect;
      sq_org[0]  <= b_org;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    localparam int BIT = CW - 1 - k;
    logic [SUMSQ_WIDTH:0] trial;
    logic                 take;

    assign trial = ({{(SUMSQ_WIDTH + 1 - CW){1'b0}}, sq_root[k]} << (BIT + 1))
                 + ((SUMSQ_WIDTH + 1)'(1) << (2 * BIT));
    assign take  = ({1'b0, sq_rem[k]} >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[k+1]  <= take ? (sq_rem[k] - trial[SUMSQ_WIDTH-1:0]) : sq_rem[k];
        sq_root[k+1] <= take ? (sq_root[k] | (CW'(1) << BIT)) : sq_root[k];
        sq_rect[k+1] <= sq_rect[k];
        sq_org[k+1]  <= sq_org[k];
      end
    end
  end

  // Weighted blend of circular and square distance.
  logic                               d_v;
  logic [CW+WEIGHT_WIDTH-1:0]         d_mc;
  logic [CW+WEIGHT_WIDTH-1:0]         d_mr;
  logic                               d_org;
  logic [CW+WEIGHT_WIDTH:0]           e_sum;
  logic                               e_v;
  logic [READ_WIDTH-1:0]              e_read;
  logic                               e_org;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_mc  <= w_inv * sq_root[CW];
      d_mr  <= w_eff * sq_rect[CW];
      d_org <= sq_org[CW];
    end
  end

  assign e_sum = {1'b0, d_mc} + {1'b0, d_mr} + (CW + WEIGHT_WIDTH + 1)'(32768);

  always_ff @(posedge clk) begin
    if (adv) begin
      e_read <= READ_WIDTH'(e_sum[CW+15:16]);
      e_org  <= d_org;
    end
  end

  // Region decision and band divide, one quotient bit per stage.
  logic [READ_WIDTH-1:0]    inner_ext;
  logic [READ_WIDTH-1:0]    outer_ext;
  logic [READ_WIDTH-1:0]    read_diff;
  logic [1:0]               region_f;
  logic [DIV_REM_WIDTH-1:0] dv_rem [0:DS];
  logic [T_FRAC:0]          dv_q   [0:DS];
  logic [1:0]               dv_reg [0:DS];
  logic                     dv_v   [0:DS];

  assign inner_ext = READ_WIDTH'(inner_radius);
  assign outer_ext = READ_WIDTH'(outer_radius);
  assign read_diff = e_read - inner_ext;

  always_comb begin
    if (e_org) begin
      region_f = REGION_ORIGIN;
    end else if (e_read > outer_ext) begin
      region_f = REGION_OUTSIDE;
    end else if (e_read >= inner_ext) begin
      region_f = REGION_BAND;
    end else begin
      region_f = REGION_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0] <= DIV_REM_WIDTH'(read_diff[RADIUS_WIDTH-1:0]);
      dv_q[0]   <= '0;
      dv_reg[0] <= region_f;
    end
  end

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [DIV_REM_WIDTH-1:0] shifted;
    logic                     take;

    assign shifted = (j == 0) ? dv_rem[j] : (dv_rem[j] << 1);
    assign take    = (shifted >= DIV_REM_WIDTH'(span));

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[j+1] <= take ? (shifted - DIV_REM_WIDTH'(span)) : shifted;
        dv_q[j+1]   <= take ? (dv_q[j] | ((T_FRAC + 1)'(1) << (T_FRAC - j))) : dv_q[j];
        dv_reg[j+1] <= dv_reg[j];
      end
    end
  end

  // Fold to the first half and square.
  logic [T_FRAC:0]     t_val;
  logic                g_up;
  logic [T_FRAC-1:0]   g_s;
  logic [1:0]          g_reg;
  logic                g_v;
  logic [2*T_FRAC-1:0] h_ssq;
  logic                h_up;
  logic [1:0]          h_reg;
  logic                h_v;

  assign t_val = dv_q[DS];

  always_ff @(posedge clk) begin
    if (adv) begin
      g_up  <= (t_val > ((T_FRAC + 1)'(1) << (T_FRAC - 1)));
      g_s   <= (t_val > ((T_FRAC + 1)'(1) << (T_FRAC - 1)))
             ? T_FRAC'(((T_FRAC + 1)'(1) << T_FRAC) - t_val) : t_val[T_FRAC-1:0];
      g_reg <= dv_reg[DS];
      h_ssq <= g_s * g_s;
      h_up  <= g_up;
      h_reg <= g_reg;
    end
  end

  // Horner evaluation of the cosine series in y = s^2.
  logic [Y_WIDTH-1:0]    hr_y    [0:HORNER_STEPS];
  logic [PROD_WIDTH-1:0] hr_prod [0:HORNER_STEPS];
  logic                  hr_up   [0:HORNER_STEPS];
  logic [1:0]            hr_reg  [0:HORNER_STEPS];
  logic                  hr_v    [0:HORNER_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      hr_y[0]    <= h_ssq[Y_WIDTH+17:18];
      hr_prod[0] <= '0;
      hr_up[0]   <= h_up;
      hr_reg[0]  <= h_reg;
    end
  end

  for (genvar k = 1; k <= HORNER_STEPS; k++) begin : g_horner
    logic [P_WIDTH-1:0] p;

    assign p = (k == 1) ? cos_coeff(HORNER_STEPS)
             : (cos_coeff(HORNER_STEPS + 1 - k) - P_WIDTH'(hr_prod[k-1][PROD_WIDTH-1:30]));

    always_ff @(posedge clk) begin
      if (adv) begin
        hr_prod[k] <= PROD_WIDTH'(p * hr_y[k-1]);
        hr_y[k]    <= hr_y[k-1];
        hr_up[k]   <= hr_up[k-1];
        hr_reg[k]  <= hr_reg[k-1];
      end
    end
  end

  // Final factor.
  logic signed [33:0] c_raw;
  logic [30:0]        c_val;
  logic [31:0]        g_val;
  logic [32:0]        g_round;
  logic [32:0]        f_wide;
  logic [F:0]         band_fac;
  logic [F:0]         fac_next;
  logic [1:0]         reg_last;

  assign reg_last = hr_reg[HORNER_STEPS];
  assign c_raw    = 34'sd1073741824
                  - $signed({2'b00, hr_prod[HORNER_STEPS][PROD_WIDTH-1:30]});
  assign c_val    = (c_raw < 0) ? '0
                  : ((c_raw > 34'sd1073741824) ? 31'd1073741824 : c_raw[30:0]);
  assign g_val    = hr_up[HORNER_STEPS] ? (32'd1073741824 - {1'b0, c_val})
                                        : (32'd1073741824 + {1'b0, c_val});
  assign g_round  = {1'b0, g_val} + (33'd1 << (30 - F));
  assign f_wide   = g_round >> (31 - F);
  assign band_fac = (f_wide > (33'd1 << F)) ? ((F + 1)'(1) << F) : f_wide[F:0];

  always_comb begin
    case (reg_last) inside
      REGION_ORIGIN, REGION_INSIDE: fac_next = (F + 1)'(1) << F;
      REGION_BAND:                  fac_next = empty_band ? '0 : band_fac;
      default:                      fac_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.factor <= fac_next;
      result.region <= reg_last;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      d_v          <= 1'b0;
      e_v          <= 1'b0;
      g_v          <= 1'b0;
      h_v          <= 1'b0;
      result_valid <= 1'b0;
      for (int i = 0; i <= CW; i++) sq_v[i] <= 1'b0;
      for (int i = 0; i <= DS; i++) dv_v[i] <= 1'b0;
      for (int i = 0; i <= HORNER_STEPS; i++) hr_v[i] <= 1'b0;
    end else if (adv) begin
      a_v     <= item_valid;
      b_v     <= a_v;
      sq_v[0] <= b_v;
      for (int i = 0; i < CW; i++) sq_v[i+1] <= sq_v[i];
      d_v     <= sq_v[CW];
      e_v     <= d_v;
      dv_v[0] <= e_v;
      for (int i = 0; i < DS; i++) dv_v[i+1] <= dv_v[i];
      g_v     <= dv_v[DS];
      h_v     <= g_v;
      hr_v[0] <= h_v;
      for (int i = 0; i < HORNER_STEPS; i++) hr_v[i+1] <= hr_v[i];
      result_valid <= hr_v[HORNER_STEPS];
    end
  end

endmodule

FILE: verif/radial_island_falloff_factor_test.sv
// Self-checking testbench for radial_island_falloff_factor with a predictor and handshake idling.
`timescale 1ns / 100ps

module radial_island_falloff_factor_test;
  import rif_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  radial_island_falloff_factor dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  longint unsigned inner_r = INNER_RESET;
  longint unsigned outer_r = OUTER_RESET;
  longint unsigned weight = WEIGHT_RESET;

  item_t pending_requests[$];
  result_t expected_factors[$];
  int mismatches = 0;
  int checked = 0;
  int region_hits[4] = '{0, 0, 0, 0};
  bit no_idle = 1'b0;
  bit squeeze_armed = 1'b0;
  bit squeeze_done = 1'b0;
  int squeeze_left = 0;
  int send_gap = 0;
  int stall_gap = 0;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned cos_pi(longint unsigned s);
    longint unsigned y, p;
    longint c;
    y = (s * s) >> 18;
    p = 64'd2071865;
    p = 64'd27709939 - ((p * y) >> 30);
    p = 64'd252684340 - ((p * y) >> 30);
    p = 64'd1433727481 - ((p * y) >> 30);
    p = 64'd4358008962 - ((p * y) >> 30);
    p = 64'd5298703516 - ((p * y) >> 30);
    c = longint'(64'd1 << 30) - longint'((p * y) >> 30);
    if (c < 0) c = 0;
    if (c > longint'(64'd1 << 30)) c = longint'(64'd1 << 30);
    return longint'(c);
  endfunction

  function automatic result_t falloff_predict(item_t it);
    result_t r;
    longint sx, sz;
    longint unsigned ax, az, w, circ, rect, reading, t, g, c;
    longint unsigned one;
    one = 64'd1 << FACTOR_FRAC_BITS;
    sx = it.x_coord;
    sz = it.z_coord;
    ax = (sx < 0) ? -sx : sx;
    az = (sz < 0) ? -sz : sz;
    w = (weight > 65536) ? 65536 : weight;
    if (ax == 0 && az == 0) begin
      r.factor = (FACTOR_FRAC_BITS + 1)'(one);
      r.region = REGION_ORIGIN;
    end else begin
      circ = isqrt(ax * ax + az * az);
      rect = (ax > az) ? ax : az;
      reading = ((65536 - w) * circ + w * rect + 32768) >> 16;
      if (reading > outer_r) begin
        r.factor = '0;
        r.region = REGION_OUTSIDE;
      end else if (reading >= inner_r) begin
        r.region = REGION_BAND;
        if (outer_r <= inner_r) begin
          r.factor = '0;
        end else begin
          t = ((reading - inner_r) << T_FRAC) / (outer_r - inner_r);
          if (t > (64'd1 << T_FRAC)) t = 64'd1 << T_FRAC;
          if (t <= (64'd1 << (T_FRAC - 1))) begin
            c = cos_pi(t);
            g = (64'd1 << 30) + c;
          end else begin
            c = cos_pi((64'd1 << T_FRAC) - t);
            g = (64'd1 << 30) - c;
          end
          g = (g + (64'd1 << (30 - FACTOR_FRAC_BITS))) >> (31 - FACTOR_FRAC_BITS);
          if (g > one) g = one;
          r.factor = (FACTOR_FRAC_BITS + 1)'(g);
        end
      end else begin
        r.factor = (FACTOR_FRAC_BITS + 1)'(one);
        r.region = REGION_INSIDE;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    bit accepted;
    accepted = item_valid && !item_stall;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (accepted) begin
        expected_factors.insert(expected_factors.size(), falloff_predict(item));
        void'(pending_requests.pop_front());
      end
      if (!item_valid || accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          item <= pending_requests[0];
          item_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_armed && !squeeze_done && result_valid) begin
      squeeze_done <= 1'b1;
      squeeze_left <= 400;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_factors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", result);
        end else begin
          want = expected_factors.pop_front();
          checked++;
          region_hits[want.region]++;
          if (result.factor !== want.factor || result.region !== want.region) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected factor %0d region %0d, got factor %0d region %0d",
                       want.factor, want.region, result.factor, result.region);
          end
        end
      end
      if (squeeze_left > 0) begin
        result_stall <= 1'b1;
      end else if (stall_gap > 0) begin
        stall_gap--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        stall_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input longint unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_INNER_RADIUS) inner_r = val & 64'h7FFFFF;
    else if (idx == REG_OUTER_RADIUS) outer_r = val & 64'h7FFFFF;
    else if (idx == REG_SQUARE_WEIGHT) weight = val & 64'h1FFFF;
  endtask

  task automatic send(input longint x, input longint z);
    item_t it;
    it.x_coord = x[COORD_WIDTH-1:0];
    it.z_coord = z[COORD_WIDTH-1:0];
    pending_requests.insert(pending_requests.size(), it);
  endtask

  function automatic longint pick_coord();
    int r;
    longint span, m;
    r = $urandom_range(0, 9);
    span = ((inner_r > outer_r) ? inner_r : outer_r) * 5 / 4 + 16;
    if (span > 8388607) span = 8388607;
    if (r < 7) m = $urandom_range(0, span);
    else if (r < 9) return longint'($signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8);
    else m = $urandom_range(0, 15);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic random_items(input int n);
    repeat (n) send(pick_coord(), pick_coord());
  endtask

  task automatic drain();
    wait (pending_requests.size() == 0 && expected_factors.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send(0, 0);
    send(-8388608, -8388608);
    send(8388607, 8388607);
    send(-8388608, 0);
    send(0, 8388607);
    send(1, 0);
    send(0, -1);
    send(139668, 0);
    send(0, -174586);
    send(174587, 0);
    send(150000, -20000);
    send(-120000, 120000);
    send(100000, 100000);
    send(157127, 0);
    send(-160000, 1000);
    random_items(300);
    drain();

    write_reg(REG_INNER_RADIUS, 0);
    write_reg(REG_OUTER_RADIUS, 8388607);
    write_reg(REG_SQUARE_WEIGHT, 0);
    send(1, 1);
    send(-8388608, 8388607);
    random_items(300);
    drain();

    no_idle = 1'b1;
    write_reg(REG_INNER_RADIUS, 100000);
    write_reg(REG_OUTER_RADIUS, 100000);
    write_reg(REG_SQUARE_WEIGHT, 65536);
    write_reg(REG_UNUSED, 23'h7FFFFF);
    send(100000, 0);
    send(0, -100000);
    random_items(200);
    drain();
    no_idle = 1'b0;

    write_reg(REG_INNER_RADIUS, 5000);
    write_reg(REG_OUTER_RADIUS, 4000);
    write_reg(REG_SQUARE_WEIGHT, 131071);
    send(4500, 0);
    random_items(200);
    drain();

    write_reg(REG_INNER_RADIUS, 2000);
    write_reg(REG_OUTER_RADIUS, 60000);
    write_reg(REG_SQUARE_WEIGHT, $urandom_range(0, 65536));
    no_idle = 1'b1;
    squeeze_armed = 1'b1;
    random_items(150);
    wait (pending_requests.size() < 20);
    no_idle = 1'b0;
    random_items(250);
    drain();

    repeat (4) begin
      write_reg(REG_INNER_RADIUS, $urandom_range(0, 400000));
      write_reg(REG_OUTER_RADIUS, inner_r + $urandom_range(1, 200000));
      write_reg(REG_SQUARE_WEIGHT, $urandom_range(0, 70000));
      random_items(100);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Checked %0d results over nine register settings, including empty and inverted bands.",
             checked);
    $display("Regions seen: origin %0d, inside %0d, band %0d, outside %0d.",
             region_hits[0], region_hits[1], region_hits[2], region_hits[3]);
    if (mismatches == 0 && expected_factors.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_factors.size());
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", expected_factors.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
sv/rif_pkg.sv
sv/radial_island_falloff_factor.sv
verif/radial_island_falloff_factor_test.sv
